// File: sv/crrf_pkg.sv
`timescale 1ns / 1ps
package crrf_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ITER_LIMIT = 48;
    localparam int MAG_W      = 62;
    localparam int DIVN_W     = MAG_W + FRAC_W;
    localparam int SQRT_STEPS = DIVN_W / 2;
    localparam int MUL_STEPS  = 5;

    typedef logic signed [63:0] val_t;

    localparam val_t VMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] VMAX_X = 65'sh0_3FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] CFG_TOL     = 2'd0;
    localparam logic [1:0] CFG_LOW     = 2'd1;
    localparam logic [1:0] CFG_HIGH    = 2'd2;
    localparam logic [1:0] CFG_MAXITER = 2'd3;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
        val_t      a;
        val_t      b;
    } arith_req_t;

    typedef struct packed {
        logic done;
        val_t result;
    } arith_rsp_t;

    typedef enum logic {
        ACT_EMIT,
        ACT_SEARCH
    } act_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_MUL_BB,
        ST_BRANCH,
        ST_DIV_T,
        ST_PLAN_T,
        ST_SQRT,
        ST_DIV_AL,
        ST_DIV_BE,
        ST_FA,
        ST_PLAN2,
        ST_EVAL,
        ST_DISPATCH,
        ST_SRCH_FR,
        ST_SRCH_CHK,
        ST_SRCH_LOOP,
        ST_SRCH_UPD,
        ST_EMIT
    } state_t;

    // saturating add into the internal range
    function automatic val_t addsat(input val_t a, input val_t b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s > VMAX_X) return VMAX;
            else if (s < -VMAX_X) return -VMAX;
            else return s[63:0];
        end
    endfunction

    function automatic logic [MAG_W-1:0] mag(input val_t v);
        logic [63:0] n;
        begin
            n = v[63] ? -v : v;
            return n[MAG_W-1:0];
        end
    endfunction

    // (a+b)/2, truncated toward zero
    function automatic val_t half_sum(input val_t a, input val_t b);
        val_t s;
        val_t adj;
        begin
            s   = a + b;
            adj = s + {63'b0, s[63]};
            return {adj[63], adj[63:1]};
        end
    endfunction

endpackage

// File: sv/cubic_real_root_finder_top.sv
`timescale 1ns / 1ps
// One request at a time; busy stays high until the last root has been issued.
// All work is set by the single shared multiply/divide/root unit. Results cannot stall.
// Reset (rst_n low, asynchronous) returns to idle and loads the default registers.
module cubic_real_root_finder_top import crrf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [30:0]        lead_coeff,
    input  logic signed [31:0] coeff_a,
    input  logic signed [31:0] coeff_b,
    input  logic signed [31:0] coeff_c,
    output logic               root_valid,
    output logic signed [31:0] root,
    output logic               found,
    output logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // configuration registers
    logic [15:0]        tol_reg;
    logic signed [31:0] slow_reg;
    logic [30:0]        shigh_reg;
    logic [5:0]         maxit_reg;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // cubic and intermediate values
    val_t lead_reg, lead_next;
    val_t sq_reg, sq_next;
    val_t lin_reg, lin_next;
    val_t cst_reg, cst_next;
    val_t a3_reg, a3_next;
    val_t b2_reg, b2_next;
    val_t s_reg, s_next;
    val_t d_reg, d_next;
    val_t rt_reg, rt_next;
    val_t al_reg, al_next;
    val_t be_reg, be_next;
    val_t fa_reg, fa_next;

    // Horner evaluation
    val_t       acc_reg, acc_next;
    val_t       ex_reg, ex_next;
    logic [1:0] estep_reg, estep_next;

    // plan of up to three actions
    act_t       pk_reg [3];
    act_t       pk_next [3];
    val_t       pl_reg [3];
    val_t       pl_next [3];
    val_t       pr_reg [3];
    val_t       pr_next [3];
    logic       pf_reg [3];
    logic       pf_next [3];
    logic [1:0] pn_reg, pn_next;
    logic [1:0] pi_reg, pi_next;

    // bisection
    val_t       bl_reg, bl_next;
    val_t       br_reg, br_next;
    val_t       bfl_reg, bfl_next;
    logic [5:0] it_reg, it_next;

    // pending emission and result registers
    val_t        ev_reg, ev_next;
    logic        ef_reg, ef_next;
    logic        issued_reg, issued_next;
    logic        valid_reg, valid_next;
    logic [31:0] root_reg, root_next;
    logic        found_reg, found_next;
    logic        last_reg, last_next;

    arith_req_t req;
    arith_rsp_t rsp;

    val_t       tolv, ntolv, lo_v, hi_v, s2, s4, nb, den, mid_v, ab_mid, coef;
    logic [5:0] itn;
    logic       uses_unit, ar_done, same_sign, opp_sign, small_fm, is_last;
    logic [MAG_W-1:0] tol_m;

    crrf_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign ar_done = rsp.done;

    assign tolv   = {48'b0, tol_reg};
    assign ntolv  = -tolv;
    assign tol_m  = {{(MAG_W-16){1'b0}}, tol_reg};
    assign lo_v   = {{32{slow_reg[31]}}, slow_reg};
    assign hi_v   = {33'b0, shigh_reg};
    assign itn    = (maxit_reg > 6'(ITER_LIMIT)) ? 6'(ITER_LIMIT) : maxit_reg;
    assign s2     = addsat(s_reg, s_reg);
    assign s4     = addsat(s2, s2);
    assign nb     = -b2_reg;
    assign den    = addsat(a3_reg, a3_reg);
    assign mid_v  = half_sum(bl_reg, br_reg);
    assign ab_mid = half_sum(al_reg, be_reg);

    // sign tests for the bracket and the midpoint
    assign same_sign = (bfl_reg != '0) && (acc_reg != '0) && (bfl_reg[63] == acc_reg[63]);
    assign opp_sign  = (bfl_reg != '0) && (acc_reg != '0) && (bfl_reg[63] != acc_reg[63]);
    assign small_fm  = mag(acc_reg) < tol_m;
    assign is_last   = (pi_reg == (pn_reg - 2'd1));

    always_comb
    begin
        case (estep_reg)
            2'd0:    coef = sq_reg;
            2'd1:    coef = lin_reg;
            default: coef = cst_reg;
        endcase
    end

    // hand one operation at a time to the shared unit
    always_comb
    begin
        uses_unit = 1'b1;
        req.op    = OP_MUL;
        req.a     = acc_reg;
        req.b     = ex_reg;
        case (state_reg)
            ST_MUL_S:
            begin
                req.a = a3_reg;
                req.b = lin_reg;
            end
            ST_MUL_BB:
            begin
                req.a = b2_reg;
                req.b = b2_reg;
            end
            ST_DIV_T:
            begin
                req.op = OP_DIV;
                req.a  = nb;
                req.b  = den;
            end
            ST_SQRT:
            begin
                req.op = OP_SQRT;
                req.a  = d_reg;
            end
            ST_DIV_AL:
            begin
                req.op = OP_DIV;
                req.a  = addsat(nb, -rt_reg);
                req.b  = den;
            end
            ST_DIV_BE:
            begin
                req.op = OP_DIV;
                req.a  = addsat(nb, rt_reg);
                req.b  = den;
            end
            ST_EVAL:
            begin
                req.a = acc_reg;
                req.b = ex_reg;
            end
            default: uses_unit = 1'b0;
        endcase
        req.start = uses_unit && !issued_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start) state_next = (lead_coeff == '0) ? ST_DISPATCH : ST_MUL_S;
            ST_MUL_S:
                if (ar_done) state_next = ST_MUL_BB;
            ST_MUL_BB:
                if (ar_done) state_next = ST_BRANCH;
            ST_BRANCH:
                if (d_reg < ntolv) state_next = ST_DISPATCH;
                else if (d_reg <= tolv) state_next = ST_DIV_T;
                else state_next = ST_SQRT;
            ST_DIV_T:
                if (ar_done) state_next = ST_EVAL;
            ST_PLAN_T:
                state_next = ST_DISPATCH;
            ST_SQRT:
                if (ar_done) state_next = ST_DIV_AL;
            ST_DIV_AL:
                if (ar_done) state_next = ST_DIV_BE;
            ST_DIV_BE:
                if (ar_done) state_next = ST_EVAL;
            ST_FA:
                state_next = ST_EVAL;
            ST_PLAN2:
                state_next = ST_DISPATCH;
            ST_EVAL:
                if (ar_done && estep_reg == 2'd2) state_next = ret_reg;
            ST_DISPATCH:
                state_next = (pk_reg[pi_reg] == ACT_EMIT) ? ST_EMIT : ST_EVAL;
            ST_SRCH_FR:
                state_next = ST_EVAL;
            ST_SRCH_CHK:
                state_next = same_sign ? ST_EMIT : ST_SRCH_LOOP;
            ST_SRCH_LOOP:
                state_next = (it_reg == itn) ? ST_EMIT : ST_EVAL;
            ST_SRCH_UPD:
                state_next = small_fm ? ST_EMIT : ST_SRCH_LOOP;
            ST_EMIT:
                state_next = is_last ? ST_IDLE : ST_DISPATCH;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ret_next    = ret_reg;
        lead_next   = lead_reg;
        sq_next     = sq_reg;
        lin_next    = lin_reg;
        cst_next    = cst_reg;
        a3_next     = a3_reg;
        b2_next     = b2_reg;
        s_next      = s_reg;
        d_next      = d_reg;
        rt_next     = rt_reg;
        al_next     = al_reg;
        be_next     = be_reg;
        fa_next     = fa_reg;
        acc_next    = acc_reg;
        ex_next     = ex_reg;
        estep_next  = estep_reg;
        pk_next     = pk_reg;
        pl_next     = pl_reg;
        pr_next     = pr_reg;
        pf_next     = pf_reg;
        pn_next     = pn_reg;
        pi_next     = pi_reg;
        bl_next     = bl_reg;
        br_next     = br_reg;
        bfl_next    = bfl_reg;
        it_next     = it_reg;
        ev_next     = ev_reg;
        ef_next     = ef_reg;
        valid_next  = 1'b0;
        root_next   = root_reg;
        found_next  = found_reg;
        last_next   = last_reg;

        if (ar_done) issued_next = 1'b0;
        else if (req.start) issued_next = 1'b1;
        else issued_next = issued_reg;

        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    lead_next = {33'b0, lead_coeff};
                    sq_next   = {{32{coeff_a[31]}}, coeff_a};
                    lin_next  = {{32{coeff_b[31]}}, coeff_b};
                    cst_next  = {{32{coeff_c[31]}}, coeff_c};
                    a3_next   = {33'b0, lead_coeff} + {32'b0, lead_coeff, 1'b0};
                    b2_next   = {{31{coeff_a[31]}}, coeff_a, 1'b0};
                    pi_next   = '0;
                    pn_next   = 2'd1;
                    pk_next[0] = ACT_EMIT;
                    pl_next[0] = '0;
                    pf_next[0] = 1'b0;
                end
            ST_MUL_S:
                if (ar_done) s_next = rsp.result;
            ST_MUL_BB:
                if (ar_done) d_next = addsat(rsp.result, -s4);
            ST_BRANCH:
                // no turning point: p(0) is the constant term
                if (d_reg < ntolv)
                begin
                    pn_next = 2'd1;
                    if (cst_reg < ntolv)
                    begin
                        pk_next[0] = ACT_SEARCH;
                        pl_next[0] = '0;
                        pr_next[0] = hi_v;
                    end
                    else if (cst_reg > tolv)
                    begin
                        pk_next[0] = ACT_SEARCH;
                        pl_next[0] = lo_v;
                        pr_next[0] = '0;
                    end
                    else
                    begin
                        pk_next[0] = ACT_EMIT;
                        pl_next[0] = '0;
                        pf_next[0] = 1'b1;
                    end
                end
            ST_DIV_T:
                if (ar_done)
                begin
                    al_next    = rsp.result;
                    acc_next   = lead_reg;
                    estep_next = '0;
                    ex_next    = rsp.result;
                    ret_next   = ST_PLAN_T;
                end
            ST_PLAN_T:
                if (mag(acc_reg) <= tol_m)
                begin
                    pn_next = 2'd3;
                    for (int i = 0; i < 3; i++)
                    begin
                        pk_next[i] = ACT_EMIT;
                        pl_next[i] = al_reg;
                        pf_next[i] = 1'b1;
                    end
                end
                else if (acc_reg < ntolv)
                begin
                    pn_next    = 2'd1;
                    pk_next[0] = ACT_SEARCH;
                    pl_next[0] = al_reg;
                    pr_next[0] = hi_v;
                end
                else
                begin
                    pn_next    = 2'd1;
                    pk_next[0] = ACT_SEARCH;
                    pl_next[0] = lo_v;
                    pr_next[0] = al_reg;
                end
            ST_SQRT:
                if (ar_done) rt_next = rsp.result;
            ST_DIV_AL:
                if (ar_done) al_next = rsp.result;
            ST_DIV_BE:
                if (ar_done)
                begin
                    be_next    = rsp.result;
                    acc_next   = lead_reg;
                    estep_next = '0;
                    ex_next    = al_reg;
                    ret_next   = ST_FA;
                end
            ST_FA:
            begin
                fa_next    = acc_reg;
                acc_next   = lead_reg;
                estep_next = '0;
                ex_next    = be_reg;
                ret_next   = ST_PLAN2;
            end
            ST_PLAN2:
                // fa in fa_reg, fb in acc_reg; cases tested in order
                if (fa_reg > tolv && acc_reg < ntolv)
                begin
                    pn_next    = 2'd3;
                    pk_next[0] = ACT_SEARCH;
                    pl_next[0] = lo_v;
                    pr_next[0] = al_reg;
                    pk_next[1] = ACT_SEARCH;
                    pl_next[1] = al_reg;
                    pr_next[1] = be_reg;
                    pk_next[2] = ACT_SEARCH;
                    pl_next[2] = be_reg;
                    pr_next[2] = hi_v;
                end
                else if (fa_reg > tolv && mag(acc_reg) < tol_m)
                begin
                    pn_next    = 2'd3;
                    pk_next[0] = ACT_EMIT;
                    pl_next[0] = be_reg;
                    pf_next[0] = 1'b1;
                    pk_next[1] = ACT_EMIT;
                    pl_next[1] = be_reg;
                    pf_next[1] = 1'b1;
                    pk_next[2] = ACT_SEARCH;
                    pl_next[2] = lo_v;
                    pr_next[2] = al_reg;
                end
                else if (acc_reg < ntolv && mag(fa_reg) < tol_m)
                begin
                    pn_next    = 2'd3;
                    pk_next[0] = ACT_EMIT;
                    pl_next[0] = al_reg;
                    pf_next[0] = 1'b1;
                    pk_next[1] = ACT_EMIT;
                    pl_next[1] = al_reg;
                    pf_next[1] = 1'b1;
                    pk_next[2] = ACT_SEARCH;
                    pl_next[2] = be_reg;
                    pr_next[2] = hi_v;
                end
                else if (fa_reg > tolv && acc_reg > tolv)
                begin
                    pn_next    = 2'd1;
                    pk_next[0] = ACT_SEARCH;
                    pl_next[0] = lo_v;
                    pr_next[0] = al_reg;
                end
                else if (fa_reg < ntolv && acc_reg < ntolv)
                begin
                    pn_next    = 2'd1;
                    pk_next[0] = ACT_SEARCH;
                    pl_next[0] = be_reg;
                    pr_next[0] = hi_v;
                end
                else
                begin
                    pn_next = 2'd3;
                    for (int i = 0; i < 3; i++)
                    begin
                        pk_next[i] = ACT_EMIT;
                        pl_next[i] = ab_mid;
                        pf_next[i] = 1'b1;
                    end
                end
            ST_EVAL:
                if (ar_done)
                begin
                    acc_next   = addsat(rsp.result, coef);
                    estep_next = estep_reg + 2'd1;
                end
            ST_DISPATCH:
                if (pk_reg[pi_reg] == ACT_EMIT)
                begin
                    ev_next = pl_reg[pi_reg];
                    ef_next = pf_reg[pi_reg];
                end
                else
                begin
                    bl_next    = pl_reg[pi_reg];
                    br_next    = pr_reg[pi_reg];
                    acc_next   = lead_reg;
                    estep_next = '0;
                    ex_next    = pl_reg[pi_reg];
                    ret_next   = ST_SRCH_FR;
                end
            ST_SRCH_FR:
            begin
                bfl_next   = acc_reg;
                acc_next   = lead_reg;
                estep_next = '0;
                ex_next    = br_reg;
                ret_next   = ST_SRCH_CHK;
            end
            ST_SRCH_CHK:
                if (same_sign)
                begin
                    ev_next = '0;
                    ef_next = 1'b0;
                end
                else
                begin
                    it_next = '0;
                end
            ST_SRCH_LOOP:
                if (it_reg == itn)
                begin
                    ev_next = mid_v;
                    ef_next = 1'b1;
                end
                else
                begin
                    acc_next   = lead_reg;
                    estep_next = '0;
                    ex_next    = mid_v;
                    ret_next   = ST_SRCH_UPD;
                end
            ST_SRCH_UPD:
                if (small_fm)
                begin
                    ev_next = mid_v;
                    ef_next = 1'b1;
                end
                else
                begin
                    // keep the half whose ends differ in sign
                    if (opp_sign) br_next = mid_v;
                    else
                    begin
                        bl_next  = mid_v;
                        bfl_next = acc_reg;
                    end
                    it_next = it_reg + 6'd1;
                end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                if (ev_reg > 64'sh7FFF_FFFF) root_next = 32'h7FFF_FFFF;
                else if (ev_reg < -64'sh8000_0000) root_next = 32'h8000_0000;
                else root_next = ev_reg[31:0];
                found_next = ef_reg;
                last_next  = is_last;
                pi_next    = pi_reg + 2'd1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            valid_reg  <= 1'b0;
            tol_reg    <= 16'd1;
            slow_reg   <= -32'sd6553600;
            shigh_reg  <= 31'd6553600;
            maxit_reg  <= 6'd48;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            valid_reg  <= valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOL:     tol_reg   <= cfg_data[15:0];
                    CFG_LOW:     slow_reg  <= cfg_data;
                    CFG_HIGH:    shigh_reg <= cfg_data[30:0];
                    CFG_MAXITER: maxit_reg <= cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ret_reg   <= ret_next;
        lead_reg  <= lead_next;
        sq_reg    <= sq_next;
        lin_reg   <= lin_next;
        cst_reg   <= cst_next;
        a3_reg    <= a3_next;
        b2_reg    <= b2_next;
        s_reg     <= s_next;
        d_reg     <= d_next;
        rt_reg    <= rt_next;
        al_reg    <= al_next;
        be_reg    <= be_next;
        fa_reg    <= fa_next;
        acc_reg   <= acc_next;
        ex_reg    <= ex_next;
        estep_reg <= estep_next;
        pk_reg    <= pk_next;
        pl_reg    <= pl_next;
        pr_reg    <= pr_next;
        pf_reg    <= pf_next;
        pn_reg    <= pn_next;
        pi_reg    <= pi_next;
        bl_reg    <= bl_next;
        br_reg    <= br_next;
        bfl_reg   <= bfl_next;
        it_reg    <= it_next;
        ev_reg    <= ev_next;
        ef_reg    <= ef_next;
        root_reg  <= root_next;
        found_reg <= found_next;
        last_reg  <= last_next;
    end

    assign root_valid = valid_reg;
    assign root       = root_reg;
    assign found      = found_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without an emit step");

    a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && lead_coeff != '0) |=> (state_reg == ST_MUL_S))
        else $error("request with nonzero lead did not start the discriminant");

    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !issued_reg)
        else $error("arithmetic operation outstanding while idle");

    a_plan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISPATCH) |-> (pi_reg < pn_reg))
        else $error("plan index beyond plan length");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_LOOP) |-> (it_reg <= itn))
        else $error("bisection ran past its halving limit");
`endif

endmodule

// File: sv/crrf_arith.sv
`timescale 1ns / 1ps
module crrf_arith import crrf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    arith_op_t         op_reg, op_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic [MAG_W-1:0]  ma_reg, ma_next;
    logic [MAG_W-1:0]  mb_reg, mb_next;
    logic [63:0]       pp_reg, pp_next;
    logic [127:0]      acc_reg, acc_next;
    logic [DIVN_W-1:0] nd_reg, nd_next;
    logic [63:0]       rem_reg, rem_next;
    logic [DIVN_W-1:0] q_reg, q_next;
    val_t              res_reg, res_next;

    logic [31:0]  m_x, m_y;
    logic [63:0]  m_p;
    logic [6:0]   sh;
    logic [63:0]  cmp_a, cmp_b, diff;
    logic         ge;
    val_t         mres, dres;

    assign m_p  = m_x * m_y;
    assign ge   = cmp_a >= cmp_b;
    assign diff = cmp_a - cmp_b;

    always_comb
    begin
        // partial product selection for the four 32x32 slices
        case (cnt_reg[1:0])
            2'd0:
            begin
                m_x = ma_reg[31:0];
                m_y = mb_reg[31:0];
            end
            2'd1:
            begin
                m_x = ma_reg[31:0];
                m_y = {2'b0, mb_reg[MAG_W-1:32]};
            end
            2'd2:
            begin
                m_x = {2'b0, ma_reg[MAG_W-1:32]};
                m_y = mb_reg[31:0];
            end
            default:
            begin
                m_x = {2'b0, ma_reg[MAG_W-1:32]};
                m_y = {2'b0, mb_reg[MAG_W-1:32]};
            end
        endcase
        case (cnt_reg)
            7'd1:    sh = 7'd0;
            7'd4:    sh = 7'd64;
            default: sh = 7'd32;
        endcase
    end

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            cmp_a = {rem_reg[61:0], nd_reg[DIVN_W-1:DIVN_W-2]};
            cmp_b = {q_reg[61:0], 2'b01};
        end
        else
        begin
            cmp_a = {rem_reg[62:0], nd_reg[DIVN_W-1]};
            cmp_b = {2'b0, mb_reg};
        end
    end

    always_comb
    begin
        val_t m;
        val_t d;
        m = (|acc_reg[127:MAG_W+FRAC_W]) ? VMAX : {2'b0, acc_reg[MAG_W+FRAC_W-1:FRAC_W]};
        mres = neg_reg ? -m : m;
        d = (|q_reg[DIVN_W-1:MAG_W]) ? VMAX : {2'b0, q_reg[MAG_W-1:0]};
        if (zero_reg) dres = '0;
        else dres = neg_reg ? -d : d;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        nd_next   = nd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        res_next  = res_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                cnt_next  = '0;
                neg_next  = req.a[63] ^ req.b[63];
                zero_next = (req.b == '0);
                ma_next   = mag(req.a);
                mb_next   = mag(req.b);
                acc_next  = '0;
                rem_next  = '0;
                q_next    = '0;
                case (req.op)
                    OP_SQRT:  nd_next = req.a[63] ? '0 : {req.a[MAG_W-1:0], {FRAC_W{1'b0}}};
                    default:  nd_next = {mag(req.a), {FRAC_W{1'b0}}};
                endcase
            end
        end
        else
        begin
            cnt_next = cnt_reg + 7'd1;
            case (op_reg)
                OP_MUL:
                begin
                    pp_next = m_p;
                    if (cnt_reg != 7'd0) acc_next = acc_reg + ({64'b0, pp_reg} << sh);
                    if (cnt_reg == 7'(MUL_STEPS))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = mres;
                    end
                end
                OP_DIV:
                begin
                    if (cnt_reg == 7'(DIVN_W))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = dres;
                    end
                    else
                    begin
                        rem_next = ge ? diff : cmp_a;
                        q_next   = {q_reg[DIVN_W-2:0], ge};
                        nd_next  = {nd_reg[DIVN_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    if (cnt_reg == 7'(SQRT_STEPS))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = {2'b0, q_reg[MAG_W-1:0]};
                    end
                    else
                    begin
                        rem_next = ge ? diff : cmp_a;
                        q_next   = {q_reg[DIVN_W-2:0], ge};
                        nd_next  = {nd_reg[DIVN_W-3:0], 2'b00};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        pp_reg   <= pp_next;
        acc_reg  <= acc_next;
        nd_reg   <= nd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// File: bench/root_checker.sv
`timescale 1ns / 1ps
module root_checker import crrf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [30:0]        lead_coeff,
    input  logic signed [31:0] coeff_a,
    input  logic signed [31:0] coeff_b,
    input  logic signed [31:0] coeff_c,
    input  logic               root_valid,
    input  logic signed [31:0] root,
    input  logic               found,
    input  logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 failures,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] root;
        logic               found;
        logic               last;
    } root_rec_t;

    root_rec_t expected_roots[$];

    logic [15:0]        tol_reg;
    logic signed [31:0] low_reg;
    logic [30:0]        high_reg;
    logic [5:0]         iter_reg;
    val_t               p_lead, p_sq, p_lin, p_cst;

    root_rec_t          batch[3];
    int                 batch_n;

    function automatic val_t clampv(input logic signed [127:0] v);
        if (v > 128'sd4611686018427387903) return VMAX;
        if (v < -128'sd4611686018427387903) return -VMAX;
        return v[63:0];
    endfunction

    function automatic val_t sadd(input val_t a, input val_t b);
        return clampv(128'(a) + 128'(b));
    endfunction

    function automatic logic [127:0] abs128(input val_t v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic val_t qmul(input val_t p, input val_t x);
        logic [127:0] prod;
        val_t         r;
        prod = abs128(p) * abs128(x);
        if (prod[127:78] != 0) r = VMAX;
        else r = val_t'(prod[79:16]);
        return (p[63] ^ x[63]) ? -r : r;
    endfunction

    function automatic val_t qdiv(input val_t num, input val_t den);
        logic [127:0] q;
        val_t         r;
        if (den == 0) return 0;
        q = (abs128(num) << 16) / abs128(den);
        r = (q > 128'(VMAX)) ? VMAX : val_t'(q[63:0]);
        return ((num < 0) != (den < 0)) ? -r : r;
    endfunction

    function automatic val_t qsqrt(input val_t d);
        logic [127:0] t, c;
        logic [127:0] y;
        t = (d < 0 ? 128'd0 : 128'(d)) << 16;
        y = 0;
        for (int b = 47; b >= 0; b--) begin
            c = y | (128'd1 << b);
            if (c * c <= t) y = c;
        end
        return val_t'(y[63:0]);
    endfunction

    function automatic val_t poly_at(input val_t x);
        val_t acc;
        acc = sadd(qmul(p_lead, x), p_sq);
        acc = sadd(qmul(acc, x), p_lin);
        return sadd(qmul(acc, x), p_cst);
    endfunction

    function automatic int sgn(input val_t v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic void emit(input val_t v, input logic ok);
        val_t s;
        s = v;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        batch[batch_n].root  = s[31:0];
        batch[batch_n].found = ok;
        batch[batch_n].last  = 1'b0;
        batch_n++;
    endfunction

    function automatic void bracket(input val_t l_in, input val_t r_in);
        val_t l, r, m, fm;
        int   n;
        l = l_in;
        r = r_in;
        n = (iter_reg > ITER_LIMIT) ? ITER_LIMIT : int'(iter_reg);
        if (sgn(poly_at(l)) * sgn(poly_at(r)) > 0) begin
            emit(0, 1'b0);
            return;
        end
        for (int i = 0; i < n; i++) begin
            m  = (l + r) / 2;
            fm = poly_at(m);
            if (abs128(fm) < 128'(tol_reg)) begin
                emit(m, 1'b1);
                return;
            end
            if (sgn(poly_at(l)) * sgn(fm) < 0) r = m;
            else l = m;
        end
        emit((l + r) / 2, 1'b1);
    endfunction

    function automatic void solve_cubic();
        val_t lo, hi, tol, a3, b2, s, disc, t, ft, den, sq, al, be, fa, fb;
        lo  = val_t'(low_reg);
        hi  = val_t'({33'b0, high_reg});
        tol = val_t'({48'b0, tol_reg});
        batch_n = 0;
        if (p_lead == 0) begin
            emit(0, 1'b0);
        end else begin
            a3   = sadd(sadd(p_lead, p_lead), p_lead);
            b2   = sadd(p_sq, p_sq);
            s    = qmul(a3, p_lin);
            s    = sadd(sadd(s, s), sadd(s, s));
            disc = sadd(qmul(b2, b2), -s);
            if (disc < -tol) begin
                t = poly_at(0);
                if (t < -tol) bracket(0, hi);
                else if (t > tol) bracket(lo, 0);
                else emit(0, 1'b1);
            end else if (disc <= tol) begin
                t  = qdiv(-b2, sadd(a3, a3));
                ft = poly_at(t);
                if (abs128(ft) <= 128'(tol)) begin
                    emit(t, 1'b1); emit(t, 1'b1); emit(t, 1'b1);
                end else if (ft < -tol) bracket(t, hi);
                else bracket(lo, t);
            end else begin
                den = sadd(a3, a3);
                sq  = qsqrt(disc);
                al  = qdiv(sadd(-b2, -sq), den);
                be  = qdiv(sadd(-b2, sq), den);
                fa  = poly_at(al);
                fb  = poly_at(be);
                if (fa > tol && fb < -tol) begin
                    bracket(lo, al); bracket(al, be); bracket(be, hi);
                end else if (fa > tol && abs128(fb) < 128'(tol)) begin
                    emit(be, 1'b1); emit(be, 1'b1); bracket(lo, al);
                end else if (fb < -tol && abs128(fa) < 128'(tol)) begin
                    emit(al, 1'b1); emit(al, 1'b1); bracket(be, hi);
                end else if (fa > tol && fb > tol) begin
                    bracket(lo, al);
                end else if (fa < -tol && fb < -tol) begin
                    bracket(be, hi);
                end else begin
                    t = (al + be) / 2;
                    emit(t, 1'b1); emit(t, 1'b1); emit(t, 1'b1);
                end
            end
        end
        batch[batch_n - 1].last = 1'b1;
        for (int i = 0; i < batch_n; i++)
            expected_roots.insert(expected_roots.size(), batch[i]);
    endfunction

    initial failures = 0;

    // Sample at the falling edge: everything is settled for the coming rising edge.
    always @(negedge clk) begin
        root_rec_t e;
        if (!rst_n) begin
            tol_reg  = 16'd1;
            low_reg  = -32'sd6553600;
            high_reg = 31'd6553600;
            iter_reg = 6'd48;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TOL:     tol_reg  = cfg_data[15:0];
                    CFG_LOW:     low_reg  = cfg_data;
                    CFG_HIGH:    high_reg = cfg_data[30:0];
                    CFG_MAXITER: iter_reg = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (root_valid) begin
                if (expected_roots.size() == 0) begin
                    $display("%0t: unexpected root %0d found %0b last %0b",
                             $time, root, found, last);
                    failures++;
                end else begin
                    e = expected_roots.pop_front();
                    if (e.root !== root || e.found !== found || e.last !== last) begin
                        $display("%0t: expected root %0d found %0b last %0b, got %0d %0b %0b",
                                 $time, e.root, e.found, e.last, root, found, last);
                        failures++;
                    end
                end
            end
            if (start && !busy) begin
                p_lead = val_t'({33'b0, lead_coeff});
                p_sq   = val_t'(coeff_a);
                p_lin  = val_t'(coeff_b);
                p_cst  = val_t'(coeff_c);
                solve_cubic();
            end
        end
        pending = expected_roots.size();
    end

endmodule

// File: bench/cubic_real_root_finder_top_test.sv
`timescale 1ns / 1ps
module cubic_real_root_finder_top_test;
    import crrf_pkg::*;

    localparam int  STALL_LIMIT = 20000;
    localparam int  ONE         = 65536;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [30:0]        lead_coeff;
    logic signed [31:0] coeff_a, coeff_b, coeff_c;
    logic               root_valid;
    logic signed [31:0] root;
    logic               found;
    logic               last;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 failures;
    int                 pending;
    int                 quiet_cycles;
    bit                 no_gaps;

    cubic_real_root_finder_top dut (.*);

    root_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up after a long stretch with neither a request nor a root.
    always @(negedge clk) begin
        if ((start && !busy) || root_valid || !rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request after a random gap (none while no_gaps is set) and hold it until taken.
    task automatic send_cubic(input logic [30:0] ld, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c);
        int  gap;
        bit  taken;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        lead_coeff <= ld;
        coeff_a    <= a;
        coeff_b    <= b;
        coeff_c    <= c;
        do begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
    endtask

    // Drop start and wait until every outstanding root has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        do @(posedge clk); while (pending != 0 || busy);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] tol, input logic signed [31:0] lo,
                            input logic [30:0] hi, input logic [5:0] iters);
        write_reg(CFG_TOL, {16'b0, tol});
        write_reg(CFG_LOW, lo);
        write_reg(CFG_HIGH, {1'b0, hi});
        write_reg(CFG_MAXITER, {26'b0, iters});
        @(posedge clk);
    endtask

    // Mostly cubics with known integer roots, the rest random coefficients, half of them arbitrary bit patterns.
    task automatic random_cubics(input int n);
        longint ld, r1, r2, r3;
        for (int i = 0; i < n; i++) begin
            no_gaps = (i % 40) < 8;
            if ($urandom_range(0, 9) < 7) begin
                ld = $urandom_range(1, 3);
                r1 = $urandom_range(0, 20) - 10;
                r2 = $urandom_range(0, 1) ? r1 : $urandom_range(0, 20) - 10;
                r3 = $urandom_range(0, 20) - 10;
                send_cubic(31'(ld * ONE), 32'(-ld * (r1 + r2 + r3) * ONE),
                           32'(ld * (r1 * r2 + r1 * r3 + r2 * r3) * ONE),
                           32'(-ld * r1 * r2 * r3 * ONE));
            end else if ($urandom_range(0, 1)) begin
                send_cubic(31'($urandom_range(1, 4 * ONE)), 32'($urandom_range(0, 40 * ONE))
                           - 20 * ONE, 32'($urandom_range(0, 200 * ONE)) - 100 * ONE,
                           $urandom);
            end else begin
                send_cubic(31'($urandom_range(1, 32'h7FFF_FFFF)), $urandom, $urandom,
                           $urandom);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        rst_n      = 1'b0;
        start      = 1'b0;
        lead_coeff = '0;
        coeff_a    = '0;
        coeff_b    = '0;
        coeff_c    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_TOL;
        cfg_data   = '0;
        no_gaps    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cubics under the reset register values.
        send_cubic(31'(ONE), 0, ONE, 5 * ONE);              // no turning point, root left of zero
        send_cubic(31'(ONE), 0, ONE, -5 * ONE);             // no turning point, root right of zero
        send_cubic(31'(ONE), 0, ONE, 0);                    // no turning point, root at zero
        send_cubic(31'(ONE), 0, 0, 0);                      // triple root
        send_cubic(31'(ONE), 0, 0, -ONE);                   // single turning point below zero
        send_cubic(31'(ONE), 0, 0, ONE);                    // single turning point above zero
        send_cubic(31'(ONE), -6 * ONE, 11 * ONE, -6 * ONE); // three distinct roots
        send_cubic(31'(ONE), -ONE, -ONE, ONE);              // double root at the right turn
        send_cubic(31'(ONE), ONE, -ONE, -ONE);              // double root at the left turn
        send_cubic(31'(ONE), 0, -3 * ONE, 5 * ONE);         // both turns above zero
        send_cubic(31'(ONE), 0, -3 * ONE, -5 * ONE);        // both turns below zero
        send_cubic(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cubic(31'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cubic(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cubic(31'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cubic(31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();
        random_cubics(87);
        drain();

        // Widest limits, exact zero test.
        set_regs(16'd0, 32'h8000_0000, 31'h7FFF_FFFF, 6'd48);
        send_cubic(31'(ONE), -6 * ONE, 11 * ONE, -6 * ONE);
        random_cubics(55);
        drain();

        // Loose tolerance, collapsed limits, single halving.
        set_regs(16'hFFFF, 32'd0, 31'd0, 6'd1);
        send_cubic(31'(ONE), -6 * ONE, 11 * ONE, -6 * ONE);
        random_cubics(45);
        drain();

        // Random middle settings.
        set_regs(16'($urandom), -32'($urandom_range(0, 32'h7FFF_FFFF)),
                 31'($urandom_range(0, 32'h7FFF_FFFF)), 6'($urandom_range(1, 48)));
        random_cubics(45);
        drain();

        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
